FILE: hdl/wobi_pkg.sv
// ----------------------------------------------------------------------------
// wobi_pkg: shared types, constants and tables for the OFDM bit interleaver
// Modulation codes, symbol geometry per modulation and the read request
// that the control logic hands to the symbol store.
// ----------------------------------------------------------------------------
package wobi_pkg;

    // Modulation codes
    localparam logic [1:0] MODE_BPSK  = 2'd0;
    localparam logic [1:0] MODE_QPSK  = 2'd1;
    localparam logic [1:0] MODE_QAM16 = 2'd2;
    localparam logic [1:0] MODE_QAM64 = 2'd3;

    // Rate codes as carried on the input stream
    localparam logic [7:0] RATE_BPSK_A  = 8'd13;
    localparam logic [7:0] RATE_BPSK_B  = 8'd15;
    localparam logic [7:0] RATE_QPSK_A  = 8'd5;
    localparam logic [7:0] RATE_QPSK_B  = 8'd7;
    localparam logic [7:0] RATE_QAM16_A = 8'd9;
    localparam logic [7:0] RATE_QAM16_B = 8'd11;
    localparam logic [7:0] RATE_QAM64_A = 8'd1;
    localparam logic [7:0] RATE_QAM64_B = 8'd3;

    localparam int unsigned SYM_BYTES_MAX = 36;
    localparam int unsigned ADDR_W        = 6;
    localparam int unsigned BIT_IDX_W     = 9;
    // SIGNAL symbol is 6 bytes; count held is one less
    localparam logic [5:0]  SIGNAL_BYTES_M1 = 6'd5;

    // Permutation geometry: N/16 - 1 and spread s - 1
    typedef struct packed {
        logic       permute;
        logic [4:0] n16_m1;
        logic [1:0] s_m1;
    } geom_t;

    localparam geom_t SIGNAL_GEOM = '{permute: 1'b1, n16_m1: 5'd2, s_m1: 2'd0};

    // One bit read from the symbol store
    typedef struct packed {
        logic                  valid;
        logic [ADDR_W-1:0]     addr;
        logic [2:0]            bit_sel;
        logic [2:0]            pos;
        logic                  final_bit;
        logic                  pkt_last;
    } rd_req_t;

    function automatic logic [1:0] rate_to_mode(input logic [7:0] code);
        logic [1:0] m;
        case (code)
            RATE_BPSK_A, RATE_BPSK_B:   m = MODE_BPSK;
            RATE_QPSK_A, RATE_QPSK_B:   m = MODE_QPSK;
            RATE_QAM16_A, RATE_QAM16_B: m = MODE_QAM16;
            RATE_QAM64_A, RATE_QAM64_B: m = MODE_QAM64;
            default:                    m = MODE_QPSK;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] mode_bytes_m1(input logic [1:0] mode);
        logic [5:0] b;
        case (mode)
            MODE_BPSK:  b = 6'd5;
            MODE_QPSK:  b = 6'd11;
            MODE_QAM16: b = 6'd23;
            MODE_QAM64: b = 6'd35;
            default:    b = 6'd11;
        endcase
        return b;
    endfunction

    function automatic geom_t mode_geom(input logic [1:0] mode);
        geom_t g;
        g.permute = 1'b1;
        case (mode)
            MODE_BPSK:
            begin
                g.n16_m1 = 5'd2;
                g.s_m1   = 2'd0;
            end
            MODE_QPSK:
            begin
                g.n16_m1 = 5'd5;
                g.s_m1   = 2'd0;
            end
            MODE_QAM16:
            begin
                g.n16_m1 = 5'd11;
                g.s_m1   = 2'd1;
            end
            MODE_QAM64:
            begin
                g.n16_m1 = 5'd17;
                g.s_m1   = 2'd2;
            end
            default:
            begin
                g.n16_m1 = 5'd5;
                g.s_m1   = 2'd0;
            end
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/wobi_perm_addr.sv
// ----------------------------------------------------------------------------
// wobi_perm_addr: source bit index generator
// Walks the output bit positions of a symbol in order and gives, for each,
// the input bit that lands there under the two-step permutation. Output
// position j is split as j = (N/16)*q + r and r = s*g + m, so the source is
// k = 16*(r - m + ((m + q) mod s)) + q, kept with plain wrapping counters.
// ----------------------------------------------------------------------------
module wobi_perm_addr (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  wobi_pkg::geom_t                     geom,
    input  logic [wobi_pkg::BIT_IDX_W-1:0]      nbits_m1,
    input  logic                                step,
    output logic [wobi_pkg::BIT_IDX_W-1:0]      bit_idx,
    output logic [2:0]                          pos,
    output logic                                final_bit
);
    import wobi_pkg::*;

    geom_t                geom_reg;
    logic [BIT_IDX_W-1:0] nbits_m1_reg;
    logic [BIT_IDX_W-1:0] j_reg;
    logic [4:0]           r_reg;
    logic [3:0]           q_reg;
    logic [1:0]           m_reg;
    logic [1:0]           qm_reg;

    logic [2:0] rot_sum;
    logic [2:0] s_full;
    logic [2:0] rot;
    logic [4:0] r_src;

    // Rotation within a group of s positions
    always_comb
    begin
        rot_sum = {1'b0, m_reg} + {1'b0, qm_reg};
        s_full  = {1'b0, geom_reg.s_m1} + 3'd1;
        rot     = (rot_sum >= s_full) ? (rot_sum - s_full) : rot_sum;
        r_src   = r_reg - {3'b000, m_reg} + {3'b000, rot[1:0]};
    end

    assign bit_idx   = geom_reg.permute ? {r_src, q_reg} : j_reg;
    // Bit position within the output byte follows the output index
    assign pos       = j_reg[2:0];
    assign final_bit = (j_reg == nbits_m1_reg);

    // Load geometry on start, advance one position per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg     <= '0;
            nbits_m1_reg <= '0;
            j_reg        <= '0;
            r_reg        <= '0;
            q_reg        <= '0;
            m_reg        <= '0;
            qm_reg       <= '0;
        end
        else if (start)
        begin
            geom_reg     <= geom;
            nbits_m1_reg <= nbits_m1;
            j_reg        <= '0;
            r_reg        <= '0;
            q_reg        <= '0;
            m_reg        <= '0;
            qm_reg       <= '0;
        end
        else if (step)
        begin
            j_reg <= j_reg + 9'd1;
            m_reg <= (m_reg == geom_reg.s_m1) ? 2'd0 : m_reg + 2'd1;
            if (r_reg == geom_reg.n16_m1)
            begin
                r_reg  <= '0;
                q_reg  <= q_reg + 4'd1;
                qm_reg <= (qm_reg == geom_reg.s_m1) ? 2'd0 : qm_reg + 2'd1;
            end
            else
            begin
                r_reg <= r_reg + 5'd1;
            end
        end
    end

endmodule

FILE: hdl/wobi_store.sv
// ----------------------------------------------------------------------------
// wobi_store: symbol memory, bit gather and output register
// Holds the bytes of the current symbol, reads one bit per request, packs
// eight returned bits into a byte and offers it on the master side.
// ----------------------------------------------------------------------------
module wobi_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [wobi_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [7:0]                      wr_data,
    input  wobi_pkg::rd_req_t               rd_req,
    output logic                            slot_free,
    output logic [7:0]                      m_tdata,    // [7:0] out_byte
    output logic                            m_tlast,    // out_last
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import wobi_pkg::*;

    logic [7:0] mem [SYM_BYTES_MAX];
    logic [7:0] rd_data_reg;

    logic       rd_valid_reg;
    logic [2:0] bit_sel_reg;
    logic [2:0] pos_reg;
    logic       final_reg;
    logic       last_reg;

    logic [6:0] asm_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_valid_reg;

    logic       rx_bit;
    logic       load_out;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_req.valid)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    // Track each read in step with the registered memory output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            bit_sel_reg  <= '0;
            pos_reg      <= '0;
            final_reg    <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_req.valid;
            bit_sel_reg  <= rd_req.bit_sel;
            pos_reg      <= rd_req.pos;
            final_reg    <= rd_req.final_bit;
            last_reg     <= rd_req.pkt_last;
        end
    end

    assign rx_bit   = rd_data_reg[bit_sel_reg];
    assign load_out = rd_valid_reg && (pos_reg == 3'd7);

    // Gather bits into the assembly byte
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg && (pos_reg != 3'd7))
        begin
            asm_reg[pos_reg] <= rx_bit;
        end
        if (load_out)
        begin
            out_data_reg <= {rx_bit, asm_reg};
            out_last_reg <= final_reg && last_reg;
        end
    end

    // Output beat valid: set on a completed byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;
    assign m_tvalid  = out_valid_reg;

    // A completed byte never lands on an occupied, stalled output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("completed byte would overwrite a pending output beat");

    // The last bit of a symbol always closes a byte
    a_final_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg && final_reg) |-> (pos_reg == 3'd7))
        else $error("symbol ended mid-byte");

    // A new output beat only follows a completed byte
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(load_out))
        else $error("output beat appeared without a completed byte");

endmodule

FILE: hdl/wlan_ofdm_bit_interleaver_core.sv
// ----------------------------------------------------------------------------
// wlan_ofdm_bit_interleaver_core: 802.11a style block bit interleaver
// Collects packet bytes into a symbol memory and emits each symbol with its
// bits permuted, or unchanged for a short packet or a trailing part symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one packet byte per beat on s_tdata, the rate code on
//   s_tuser (read on the first byte of a packet), s_tlast on the final byte.
//   Master side: one output byte per beat on m_tdata, m_tlast on the final
//   output byte of the packet.
//   The first 6 bytes form the SIGNAL symbol (BPSK permutation) if the
//   packet has that many; later symbols are 6, 12, 24 or 36 bytes by rate.
//   Filling takes one cycle per byte. A beat that completes a symbol, or
//   carries s_tlast, starts the emit phase: s_tready drops and the symbol
//   memory is read one bit per cycle unless a stalled receiver holds it back;
//   the bits pass through the registered memory read into the output byte.
//   The single read port of the symbol memory sets this rate.
//   A stalled receiver holds the current output beat; reading pauses before
//   the bit that would complete the next byte until the beat is taken.
//   Reset clears control state: the next byte starts a new packet, QPSK is
//   assumed until a rate code is read, and no output beat is pending.
// ----------------------------------------------------------------------------
module wlan_ofdm_bit_interleaver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [7:0]  s_tuser,    // [7:0] rate_code
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast     // out_last
);
    import wobi_pkg::*;

    localparam logic ST_FILL = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [ADDR_W-1:0]    cnt_reg;
    logic [ADDR_W-1:0]    cnt_next;
    logic                 in_sig_reg;
    logic                 in_sig_next;
    logic [1:0]           mode_reg;
    logic [1:0]           mode_next;
    logic                 pkt_last_reg;
    logic                 pkt_last_next;

    logic                 accept;
    logic [1:0]           mode_eff;
    logic [5:0]           target_m1;
    logic                 full;
    logic                 start;
    geom_t                geom;
    logic [BIT_IDX_W-1:0] nbits_m1;

    logic                 step;
    logic                 slot_free;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [2:0]           out_pos;
    logic                 final_bit;
    rd_req_t              rd_req;

    assign s_tready = (state_reg == ST_FILL);
    assign accept   = s_tvalid && s_tready;

    // Decode the symbol size for the incoming byte
    always_comb
    begin
        mode_eff  = (in_sig_reg && (cnt_reg == '0)) ? rate_to_mode(s_tuser) : mode_reg;
        target_m1 = in_sig_reg ? SIGNAL_BYTES_M1 : mode_bytes_m1(mode_eff);
        full      = (cnt_reg == target_m1);
        start     = accept && (full || s_tlast);
        if (!full)
        begin
            geom = '{permute: 1'b0, n16_m1: 5'd0, s_m1: 2'd0};
        end
        else if (in_sig_reg)
        begin
            geom = SIGNAL_GEOM;
        end
        else
        begin
            geom = mode_geom(mode_eff);
        end
        nbits_m1 = {cnt_reg, 3'b111};
    end

    // Hold off the read that completes a byte while the output is stalled
    assign step = (state_reg == ST_EMIT) && ((out_pos != 3'd7) || slot_free);

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        in_sig_next   = in_sig_reg;
        mode_next     = mode_reg;
        pkt_last_next = pkt_last_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    mode_next = mode_eff;
                    if (start)
                    begin
                        state_next    = ST_EMIT;
                        cnt_next      = '0;
                        pkt_last_next = s_tlast;
                        in_sig_next   = s_tlast ? 1'b1 : 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (step && final_bit)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            cnt_reg      <= '0;
            in_sig_reg   <= 1'b1;
            mode_reg     <= MODE_QPSK;
            pkt_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            in_sig_reg   <= in_sig_next;
            mode_reg     <= mode_next;
            pkt_last_reg <= pkt_last_next;
        end
    end

    // Bit read request towards the store
    always_comb
    begin
        rd_req.valid     = step;
        rd_req.addr      = bit_idx[BIT_IDX_W-1:3];
        rd_req.bit_sel   = bit_idx[2:0];
        rd_req.pos       = out_pos;
        rd_req.final_bit = final_bit;
        rd_req.pkt_last  = pkt_last_reg;
    end

    wobi_perm_addr u_perm_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .geom      (geom),
        .nbits_m1  (nbits_m1),
        .step      (step),
        .bit_idx   (bit_idx),
        .pos       (out_pos),
        .final_bit (final_bit)
    );

    wobi_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_addr   (cnt_reg),
        .wr_data   (s_tdata),
        .rd_req    (rd_req),
        .slot_free (slot_free),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

FILE: bench/wobi_checker.sv
// ----------------------------------------------------------------------------
// wobi_checker: output predictor and comparator for the OFDM bit interleaver
// Watches both stream channels of the core. Every accepted input beat is run
// through a local copy of the packet/symbol state; each byte that the beat
// releases is queued, and every output beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module wobi_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] data_byte
    input  logic [7:0]        s_tuser,    // [7:0] rate_code
    input  logic              s_tlast,    // last_byte
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,    // [7:0] out_byte
    input  logic              m_tlast,    // out_last
    output int unsigned       error_count,
    output int unsigned       beats_owed
);

    timeunit 1ns;
    timeprecision 1ps;

    import wobi_pkg::*;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } out_beat_t;

    // Local copy of the core state
    logic [7:0]  sym_store [SYM_BYTES_MAX];
    logic [5:0]  fill_cnt  = '0;
    logic        in_sig    = 1'b1;
    logic [1:0]  cur_mode  = MODE_QPSK;

    out_beat_t   expected_beats [$];
    int unsigned errs = 0;

    // Two-step 802.11a permutation of the first nbytes of the symbol store
    function automatic void scramble_symbol(input int nbytes, input int s);
        logic src [SYM_BYTES_MAX*8];
        logic dst [SYM_BYTES_MAX*8];
        int   n;
        int   i;
        int   j;
        logic [7:0] v;
        n = nbytes * 8;
        for (int k = 0; k < n; k++)
            src[k] = sym_store[k / 8][k % 8];
        for (int k = 0; k < n; k++)
        begin
            i = (n / 16) * (k % 16) + k / 16;
            j = s * (i / s) + ((i + n - (16 * i) / n) % s);
            dst[j % n] = src[k];
        end
        for (int k = 0; k < nbytes; k++)
        begin
            for (int t = 0; t < 8; t++)
                v[t] = dst[k * 8 + t];
            sym_store[k] = v;
        end
    endfunction

    // Advance the packet state by one byte and queue whatever it releases
    task automatic predict_beat(input logic [7:0] b, input logic [7:0] rc, input logic lst);
        int target;
        int spread;
        int count;
        out_beat_t ob;
        // rate is only read on the opening byte of a packet
        if (in_sig && fill_cnt == 0)
        begin
            case (rc)
                RATE_BPSK_A, RATE_BPSK_B:   cur_mode = MODE_BPSK;
                RATE_QPSK_A, RATE_QPSK_B:   cur_mode = MODE_QPSK;
                RATE_QAM16_A, RATE_QAM16_B: cur_mode = MODE_QAM16;
                RATE_QAM64_A, RATE_QAM64_B: cur_mode = MODE_QAM64;
                default:                    cur_mode = MODE_QPSK;
            endcase
        end
        if (in_sig)
        begin
            target = 6;
            spread = 1;
        end
        else
        begin
            case (cur_mode)
                MODE_BPSK:
                begin
                    target = 6;
                    spread = 1;
                end
                MODE_QAM16:
                begin
                    target = 24;
                    spread = 2;
                end
                MODE_QAM64:
                begin
                    target = 36;
                    spread = 3;
                end
                default:
                begin
                    target = 12;
                    spread = 1;
                end
            endcase
        end
        sym_store[fill_cnt] = b;
        fill_cnt = fill_cnt + 6'd1;
        count = fill_cnt;
        if (count >= target || lst)
        begin
            // a full symbol is permuted; a short tail goes out unchanged
            if (count >= target)
            begin
                count = target;
                scramble_symbol(target, spread);
                in_sig = 1'b0;
            end
            for (int k = 0; k < count; k++)
            begin
                ob.octet = sym_store[k];
                ob.last  = lst && (k + 1 == count);
                expected_beats.push_back(ob);
            end
            fill_cnt = '0;
            if (lst)
                in_sig = 1'b1;
        end
    endtask

    // Predict on input beats, compare on output beats
    always @(posedge clk)
    begin : watch
        out_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_beat(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected output beat: out_byte %02h out_last %0b",
                           m_tdata, m_tlast);
                    errs++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.octet)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.octet, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        errs++;
                    end
                end
            end
        end
        error_count <= errs;
        beats_owed  <= expected_beats.size();
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the OFDM bit interleaver core
// Sends packets of every rate and length shape with random gaps, holds the
// output back at random and once for a long stretch, and leaves checking to
// the checker instance beside the core.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wobi_pkg::*;

    localparam int unsigned ITEM_TARGET = 460;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned HOLD_AT     = 120;
    localparam int unsigned TAIL_CYCLES = 50;

    localparam int unsigned FILL_RANDOM = 0;
    localparam int unsigned FILL_ONES   = 1;
    localparam int unsigned FILL_ZEROS  = 2;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int unsigned error_count;
    int unsigned beats_owed;
    int unsigned items_sent = 0;
    int unsigned beats_taken = 0;

    logic [7:0]  rate_table [8] = '{RATE_BPSK_A, RATE_BPSK_B, RATE_QPSK_A, RATE_QPSK_B,
                                    RATE_QAM16_A, RATE_QAM16_B, RATE_QAM64_A,
                                    RATE_QAM64_B};

    wlan_ofdm_bit_interleaver_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    wobi_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .beats_owed  (beats_owed)
    );

    always #5 clk = ~clk;

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic [7:0] d, input logic [7:0] rc, input logic lst);
        int unsigned gap;
        // every third block of 64 items runs back to back
        gap = ((items_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= rc;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // One packet: rate on the opening byte, noise in tuser after it
    task automatic send_packet(input logic [7:0] rate, input int unsigned len,
                               input int unsigned fill);
        logic [7:0] d;
        for (int unsigned k = 0; k < len; k++)
        begin
            case (fill)
                FILL_ONES:  d = 8'hFF;
                FILL_ZEROS: d = 8'h00;
                default:    d = 8'($urandom_range(0, 255));
            endcase
            send_beat(d, (k == 0) ? rate : 8'($urandom_range(0, 255)), k + 1 == len);
        end
    endtask

    // Receiver: random hold-off per beat, one long stall to back up the core
    initial
    begin : sink
        int unsigned w;
        forever
        begin
            if (beats_taken == HOLD_AT)
                w = HOLD_CYCLES;
            else if ((beats_taken / 80) % 4 == 3)
                w = 0;
            else
                w = $urandom_range(0, 3);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            beats_taken++;
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [7:0]  rate;
        int unsigned tgt;
        int unsigned shape;
        int unsigned len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte packets at both extremes, a short packet,
        // SIGNAL plus a trailing tail, last byte completing a data symbol
        send_packet(8'hFF, 1, FILL_ONES);
        send_packet(8'h00, 1, FILL_ZEROS);
        send_packet(RATE_QAM64_A, 4, FILL_RANDOM);
        send_packet(RATE_BPSK_B, 7, FILL_ONES);
        send_packet(RATE_BPSK_A, 12, FILL_RANDOM);

        // mostly well-formed packets of whole symbols, some ragged or short
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 8)
                rate = rate_table[$urandom_range(0, 7)];
            else
                rate = 8'($urandom_range(0, 255));
            case (rate)
                RATE_BPSK_A, RATE_BPSK_B:   tgt = 6;
                RATE_QAM16_A, RATE_QAM16_B: tgt = 24;
                RATE_QAM64_A, RATE_QAM64_B: tgt = 36;
                default:                    tgt = 12;
            endcase
            shape = $urandom_range(0, 9);
            if (shape < 2)
                len = $urandom_range(1, 5);
            else if (shape < 4)
                len = 6 + $urandom_range(0, 2 * tgt);
            else
                len = 6 + tgt * $urandom_range(1, 2);
            send_packet(rate, len, FILL_RANDOM);
        end
        s_tvalid <= 1'b0;

        // drain, then give the core time to show any stray beat
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
